>>> rtl/ascii85_stream_decoder_assert.svh
// Assertion macros used by the ASCII85 stream decoder checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASCII85_STREAM_DECODER_ASSERT_SVH
`define ASCII85_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define A85_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define A85_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/a85_pkg.sv
// Types, character codes and helper functions for the ASCII85 stream decoder.
// Depends on nothing; imported by the decoder, its checker and the bench.
package a85_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_END       = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_BAD_GROUP = 2'd3
  } a85_status_t;

  // Character codes of interest.
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!' digit value 0
  localparam logic [7:0] CH_U     = 8'h75;  // 'u' digit value 84
  localparam logic [7:0] CH_Z     = 8'h7A;  // 'z' four zero bytes
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~' end marker lead
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>' end marker tail

  localparam int unsigned GROUP_DIGITS = 5;
  localparam int unsigned SLOTS        = 4;

  // Up to four results decoded from one input word.
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [31:0]                  word;
    a85_status_t [SLOTS-1:0]      st;
  } a85_bundle_t;

  // Whitespace that is skipped between digits.
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h00) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0C) || (c == 8'h0D) || (c == 8'h20);
  endfunction

  // Padding a group of n digits with 'u' digits gives (v + 1) * 85^(5-n) - 1.
  // This returns the power of 85 for the digit counts that produce bytes.
  function automatic logic [19:0] pad_scale(input logic [2:0] n);
    logic [19:0] s;
    s = 20'd1;
    case (n)
      3'd2:    s = 20'd614125;
      3'd3:    s = 20'd7225;
      3'd4:    s = 20'd85;
      default: s = 20'd1;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/ascii85_stream_decoder.sv
// Top level of the ASCII85 stream decoder: input register, decode, result
// queue and output register. Depends on a85_pkg.
//
// Decodes one ASCII85 character per word at up to one word per cycle. Each
// character gives zero to four result words (data bytes, end of data, a
// malformed end marker, or a dropped invalid group). Results leave through a
// single output register at one word per cycle while the receiver is ready,
// so a character with several results sends them one by one; a queue of
// FIFO_DEPTH decoded bundles absorbs these bursts and the input stalls only
// when that queue is full. A character passes through the input register,
// the result queue and the output register. Once the end of data is decoded,
// every further character is consumed and dropped until reset.
module ascii85_stream_decoder
  import a85_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic [0:0] in_tuser,   // [0] source_done
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // Input register.
  logic       in_vld_r;
  logic [7:0] char_r;
  logic       done_r;

  // Decoder state.
  logic [2:0]  dc_r, dc_nxt;
  logic [31:0] gv_r, gv_nxt;
  logic        bad_r, bad_nxt;
  logic        tilde_r, tilde_nxt;
  logic        fin_r, fin_nxt;

  // Result queue.
  a85_bundle_t      fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fcnt_r;
  logic             fifo_full, fifo_empty;

  // Output register.
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  a85_status_t out_st_r;
  logic        out_last_r;
  logic [1:0]  slot_r;

  a85_bundle_t bnd;
  a85_bundle_t head;
  logic        take, push, pop, load, head_last;
  logic        is_dig;
  logic [7:0]  dval;
  logic [31:0] v85;
  logic [51:0] pad_prod;
  logic [31:0] pad_word;
  logic [7:0]  head_byte;

  assign fifo_full  = (fcnt_r == CNT_W'(FIFO_DEPTH));
  assign fifo_empty = (fcnt_r == '0);

  // An item with no results never needs queue space.
  assign take      = in_vld_r && ((bnd.cnt == 3'd0) || !fifo_full);
  assign push      = take && (bnd.cnt != 3'd0);
  assign in_tready = !in_vld_r || take;

  // Digit accumulation: v * 85 + d, with 85 = 64 + 16 + 4 + 1.
  assign is_dig = (char_r >= CH_BANG) && (char_r <= CH_U);
  assign dval   = char_r - CH_BANG;
  assign v85    = (gv_r << 6) + (gv_r << 4) + (gv_r << 2) + gv_r + {24'd0, dval};

  // Padded value of a partial group for a flush.
  assign pad_prod = {20'd0, gv_r + 32'd1} * {32'd0, pad_scale(dc_r)};
  assign pad_word = pad_prod[31:0] - 32'd1;

  // Decode one character against the group state.
  always_comb begin
    logic [2:0]  dc_inc;
    logic        bad_inc;
    logic [2:0]  nbytes;
    a85_status_t tail;
    dc_inc  = dc_r + 3'd1;
    bad_inc = bad_r | ~is_dig;
    nbytes  = (dc_r == 3'd0) ? 3'd0 : dc_r - 3'd1;
    tail    = ST_END;
    dc_nxt    = dc_r;
    gv_nxt    = gv_r;
    bad_nxt   = bad_r;
    tilde_nxt = tilde_r;
    fin_nxt   = fin_r;
    bnd.cnt   = 3'd0;
    bnd.word  = 32'd0;
    bnd.st    = {SLOTS{ST_DATA}};
    if (fin_r) begin
      // Past the end: drop everything.
    end else if (done_r || tilde_r) begin
      // End of data, with any partial group flushed first.
      if (tilde_r && (done_r || (char_r != CH_GT))) begin
        tail = ST_MALFORMED;
      end
      if ((dc_r != 3'd0) && bad_r) begin
        bnd.cnt   = 3'd2;
        bnd.st[0] = ST_BAD_GROUP;
        bnd.st[1] = tail;
      end else begin
        bnd.cnt  = nbytes + 3'd1;
        bnd.word = pad_word;
        for (int i = 0; i < SLOTS; i++) begin
          if (3'(i) == nbytes) begin
            bnd.st[i] = tail;
          end
        end
      end
      dc_nxt    = 3'd0;
      gv_nxt    = 32'd0;
      bad_nxt   = 1'b0;
      tilde_nxt = 1'b0;
      fin_nxt   = 1'b1;
    end else if (is_space(char_r)) begin
      // Whitespace is skipped.
    end else if (char_r == CH_TILDE) begin
      tilde_nxt = 1'b1;
    end else if ((char_r == CH_Z) && (dc_r == 3'd0)) begin
      // Four zero bytes.
      bnd.cnt = 3'd4;
    end else begin
      // Digit, or an invalid character that spoils the group.
      if (dc_inc == 3'(GROUP_DIGITS)) begin
        if (bad_inc) begin
          bnd.cnt   = 3'd1;
          bnd.st[0] = ST_BAD_GROUP;
        end else begin
          bnd.cnt  = 3'd4;
          bnd.word = v85;
        end
        dc_nxt  = 3'd0;
        gv_nxt  = 32'd0;
        bad_nxt = 1'b0;
      end else begin
        dc_nxt  = dc_inc;
        bad_nxt = bad_inc;
        if (is_dig) begin
          gv_nxt = v85;
        end
      end
    end
  end

  // Input register and decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      dc_r     <= 3'd0;
      gv_r     <= 32'd0;
      bad_r    <= 1'b0;
      tilde_r  <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (take) begin
        dc_r    <= dc_nxt;
        gv_r    <= gv_nxt;
        bad_r   <= bad_nxt;
        tilde_r <= tilde_nxt;
        fin_r   <= fin_nxt;
      end
    end
  end

  // Input payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      done_r <= in_tuser[0];
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= bnd;
    end
  end

  // Serialize the head bundle one slot at a time.
  assign head      = fifo_r[rd_ptr_r];
  assign head_last = ({1'b0, slot_r} == (head.cnt - 3'd1));
  assign load      = !fifo_empty && (!out_vld_r || out_tready);
  assign pop       = load && head_last;

  always_comb begin
    case (slot_r)
      2'd0:    head_byte = head.word[31:24];
      2'd1:    head_byte = head.word[23:16];
      2'd2:    head_byte = head.word[15:8];
      default: head_byte = head.word[7:0];
    endcase
  end

  // Queue pointers, output valid and slot index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fcnt_r    <= '0;
      out_vld_r <= 1'b0;
      slot_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fcnt_r <= fcnt_r + CNT_W'(push) - CNT_W'(pop);
      if (load) begin
        out_vld_r <= 1'b1;
        slot_r    <= head_last ? 2'd0 : slot_r + 2'd1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Output payload; non-data results carry a zero byte.
  always_ff @(posedge clk) begin
    if (load) begin
      out_st_r   <= head.st[slot_r];
      out_byte_r <= (head.st[slot_r] == ST_DATA) ? head_byte : 8'd0;
      out_last_r <= head_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/a85_checker.sv
// Port-level checker for the ASCII85 stream decoder, bound to its top level.
// Depends on a85_pkg and ascii85_stream_decoder_assert.svh.
`include "ascii85_stream_decoder_assert.svh"

module a85_checker
  import a85_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  logic out_fire;
  logic end_word;
  logic end_seen_r;

  assign out_fire = out_tvalid && out_tready;
  assign end_word = (out_tuser == ST_END) || (out_tuser == ST_MALFORMED);

  // Remember that the end of data has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_seen_r <= 1'b0;
    end else if (out_fire && end_word) begin
      end_seen_r <= 1'b1;
    end
  end

  // A stalled word stays valid and unchanged.
  `A85_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped while stalled")
  `A85_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output word changed while stalled")

  // Non-data results carry a zero byte.
  `A85_ASSERT_IMPLY(a_zero_byte, clk, rst_n, out_tvalid && (out_tuser != ST_DATA), out_tdata == 8'd0, "non-data result with nonzero byte")

  // The end result closes the results of its character.
  `A85_ASSERT_IMPLY(a_end_last, clk, rst_n, out_tvalid && end_word, out_tlast, "end result without tlast")

  // Nothing follows the end of data.
  `A85_ASSERT_IMPLY(a_quiet_after_end, clk, rst_n, end_seen_r, !out_tvalid, "result after end of data")

endmodule

bind ascii85_stream_decoder a85_checker u_a85_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> bench/tb.sv
// Self-checking bench for ascii85_stream_decoder: directed and random character
// streams, a predictor kept in step with every accepted word, and a result checker.
// Depends on a85_pkg and the decoder RTL; needs no other files.
module tb;
  import a85_pkg::*;

  // One decoded result as it should leave the block.
  typedef struct packed {
    logic [7:0]  data;
    a85_status_t st;
    logic        last;
  } decoded_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] character
  logic [0:0] in_tuser;   // [0] source_done
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] data_byte
  logic [1:0] out_tuser;  // [1:0] status
  logic       out_tlast;

  // Idling knobs, in percent of cycles.
  int unsigned gap_pct;
  int unsigned stall_pct;

  // Predictor state of the decoder.
  logic [2:0]  grp_digits;
  logic [31:0] grp_value;
  logic        grp_bad;
  logic        tilde_seen;
  logic        stream_ended;

  decoded_t    decoded_q[$];
  decoded_t    step_buf[4];
  int          step_cnt;
  int          words_sent;
  bit          failed;

  ascii85_stream_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver side: stall at random according to the current knob.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Bytes that the decoder skips between digits.
  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h00 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D ||
           c == 8'h20;
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'h00;
      1:       c = 8'h09;
      2:       c = 8'h0A;
      3:       c = 8'h0C;
      4:       c = 8'h0D;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range(CH_BANG, CH_U));
  endfunction

  // Any byte but the end marker lead, so that the stream keeps going.
  function automatic logic [7:0] pick_noise();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_TILDE) begin
      c = 8'hFF;
    end
    return c;
  endfunction

  task automatic add_result(input logic [7:0] b, input a85_status_t s);
    step_buf[step_cnt].data = b;
    step_buf[step_cnt].st   = s;
    step_buf[step_cnt].last = 1'b0;
    step_cnt++;
  endtask

  // Emit the bytes of the open group, padded with top digits, or one error.
  task automatic close_group();
    logic [31:0] v;
    logic [31:0] sh;
    int i;
    if (grp_digits != 3'd0) begin
      if (grp_bad) begin
        add_result(8'h00, ST_BAD_GROUP);
      end else begin
        v = grp_value;
        for (i = grp_digits; i < GROUP_DIGITS; i++) begin
          v = v * 32'd85 + 32'd84;
        end
        for (i = 0; i + 1 < grp_digits; i++) begin
          sh = v >> (24 - 8 * i);
          add_result(sh[7:0], ST_DATA);
        end
      end
    end
    grp_digits = 3'd0;
    grp_value  = 32'd0;
    grp_bad    = 1'b0;
  endtask

  // Work out the results of one accepted word and queue them.
  task automatic decode_word(input logic [7:0] c, input logic done);
    a85_status_t st;
    int i;
    step_cnt = 0;
    if (!stream_ended) begin
      if (done || tilde_seen) begin
        st = (tilde_seen && (done || c != CH_GT)) ? ST_MALFORMED : ST_END;
        close_group();
        add_result(8'h00, st);
        tilde_seen   = 1'b0;
        stream_ended = 1'b1;
      end else if (is_blank(c)) begin
        // Skipped.
      end else if (c == CH_TILDE) begin
        tilde_seen = 1'b1;
      end else if (c == CH_Z && grp_digits == 3'd0) begin
        for (i = 0; i < SLOTS; i++) begin
          add_result(8'h00, ST_DATA);
        end
      end else begin
        if (c >= CH_BANG && c <= CH_U) begin
          grp_value = grp_value * 32'd85 + 32'(c - CH_BANG);
        end else begin
          grp_bad = 1'b1;
        end
        grp_digits = grp_digits + 3'd1;
        if (grp_digits >= GROUP_DIGITS) begin
          close_group();
        end
      end
    end
    for (i = 0; i < step_cnt; i++) begin
      step_buf[i].last = (i == step_cnt - 1);
      decoded_q.push_back(step_buf[i]);
    end
  endtask

  // Offer one word, wait for the handshake, then predict its results.
  task automatic send_word(input logic [7:0] c, input logic done);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= c;
    in_tuser[0] <= done;
    do begin
      @(posedge clk);
    end while (!in_tready);
    words_sent++;
    decode_word(c, done);
  endtask

  // Check every result word against the oldest prediction.
  always @(posedge clk) begin
    decoded_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected result data=%h status=%0d last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        exp_res = decoded_q.pop_front();
        if (out_tdata !== exp_res.data) begin
          failed = 1'b1;
          $display("%0t: data_byte expected %h actual %h",
                   $time, exp_res.data, out_tdata);
        end
        if (out_tuser !== exp_res.st) begin
          failed = 1'b1;
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_res.st, out_tuser);
        end
        if (out_tlast !== exp_res.last) begin
          failed = 1'b1;
          $display("%0t: last expected %b actual %b",
                   $time, exp_res.last, out_tlast);
        end
      end
    end
  end

  task automatic test_reset();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tuser    <= 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    grp_digits   = 3'd0;
    grp_value    = 32'd0;
    grp_bad      = 1'b0;
    tilde_seen   = 1'b0;
    stream_ended = 1'b0;
    words_sent   = 0;
    failed       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Extremes: zero run, all-ones group with every blank between digits,
  // wrapping group, and a group spoiled by a mid-group 'z' and bad bytes.
  task automatic test_directed_groups();
    send_word(CH_Z, 1'b0);
    send_word("s", 1'b0);
    send_word(8'h00, 1'b0);
    send_word("8", 1'b0);
    send_word(8'h09, 1'b0);
    send_word("W", 1'b0);
    send_word(8'h0A, 1'b0);
    send_word("-", 1'b0);
    send_word(8'h0C, 1'b0);
    send_word(CH_BANG, 1'b0);
    send_word(8'h0D, 1'b0);
    repeat (5) send_word(CH_U, 1'b0);
    send_word(CH_BANG, 1'b0);
    send_word(CH_Z, 1'b0);
    send_word("v", 1'b0);
    send_word(8'h20, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_BANG, 1'b0);
  endtask

  // Mostly well-formed groups with random digits and blanks, some noise.
  task automatic test_random_stream(input int unsigned gap, input int unsigned stall,
                                    input int count);
    int stop_at;
    int i;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        send_word(CH_Z, 1'b0);
      end else begin
        for (i = 0; i < GROUP_DIGITS; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_word(pick_blank(), 1'b0);
          end
          if ($urandom_range(0, 9) == 0) begin
            send_word(pick_noise(), 1'b0);
          end else begin
            send_word(pick_digit(), 1'b0);
          end
        end
      end
    end
  endtask

  // Leave a partial group open, then end the data in one of four ways.
  task automatic test_end_of_data();
    int n;
    int i;
    logic [7:0] c;
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_word(pick_noise(), 1'b0);
      end else begin
        send_word(pick_digit(), 1'b0);
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        send_word(CH_TILDE, 1'b0);
        send_word(CH_GT, 1'b0);
      end
      1: begin
        // Any follower but '>' is a malformed end; blanks are not skipped here.
        c = 8'($urandom_range(0, 255));
        if (c == CH_GT) begin
          c = 8'h20;
        end
        send_word(CH_TILDE, 1'b0);
        send_word(c, 1'b0);
      end
      2: begin
        send_word(CH_TILDE, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  // Everything after the end must be dropped, source_done included.
  task automatic test_ignore_after_end();
    int i;
    for (i = 0; i < 12; i++) begin
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    test_reset();
    test_directed_groups();
    test_random_stream(0, 0, 12);
    test_random_stream(84, 0, 12);
    test_random_stream(0, 84, 12);
    test_random_stream(8, 8, 12);
    test_end_of_data();
    test_ignore_after_end();
    stall_pct = 0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
    if (!failed) begin
      $display("ascii85_stream_decoder: match");
    end else begin
      $display("ascii85_stream_decoder: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake or results that never arrive.
  initial begin
    #2000000;
    $display("ascii85_stream_decoder: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/a85_pkg.sv
rtl/ascii85_stream_decoder.sv
rtl/a85_checker.sv
bench/tb.sv
